[design/fte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fte_pkg
// shared types and constants of the two-electron accumulate unit
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int KIND_W = 3;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 64;
  localparam int BC_W   = 7;
  localparam int STEP_W = 3;

  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DENSITY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CORE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INTEGRAL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;
  localparam logic [BC_W-1:0]   BC_RESET  = 7'd64;

  localparam logic [4:0] SHIFT_COULOMB = 5'd22;
  localparam logic [4:0] SHIFT_EXCH    = 5'd24;

  // commands from controller to datapath
  typedef struct packed {
    logic              capture;
    logic              sweep;
    logic              dens_we;
    logic              core_we;
    logic              int_rd;
    logic              int_mul;
    logic              int_acc;
    logic              rd_a;
    logic              rd_b;
    logic              rd_g;
    logic              push;
    logic              push_err;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              bad;
    logic              sweep_last;
    logic              out_free;
  } sts_t;

endpackage
`default_nettype wire

[design/fte_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fte_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/fte_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fte_ctrl
// sequencer: decode, clearing sweep, six integral update steps, reads
// ----------------------------------------------------------------------------
module fte_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire fte_pkg::sts_t sts_i,
  output fte_pkg::cmd_t      cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_DECODE  = 11'b000_0000_0010,
    ST_CLEAR   = 11'b000_0000_0100,
    ST_INT_RD  = 11'b000_0000_1000,
    ST_INT_MUL = 11'b000_0001_0000,
    ST_INT_ACC = 11'b000_0010_0000,
    ST_RD_A    = 11'b000_0100_0000,
    ST_RD_B    = 11'b000_1000_0000,
    ST_RD_G    = 11'b001_0000_0000,
    ST_RD_OUT  = 11'b010_0000_0000,
    ST_ERR_OUT = 11'b100_0000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [fte_pkg::STEP_W-1:0]  step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        step_d = '0;
        unique case (sts_i.kind)
          fte_pkg::KIND_CLEAR: state_d = ST_CLEAR;
          fte_pkg::KIND_DENSITY: begin
            cmd_o.dens_we = !sts_i.bad;
            state_d       = sts_i.bad ? ST_ERR_OUT : ST_IDLE;
          end
          fte_pkg::KIND_CORE: begin
            cmd_o.core_we = !sts_i.bad;
            state_d       = sts_i.bad ? ST_ERR_OUT : ST_IDLE;
          end
          fte_pkg::KIND_INTEGRAL: state_d = sts_i.bad ? ST_ERR_OUT : ST_INT_RD;
          fte_pkg::KIND_READ:     state_d = sts_i.bad ? ST_ERR_OUT : ST_RD_A;
          default:                state_d = ST_IDLE;
        endcase
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_INT_RD: begin
        cmd_o.int_rd = 1'b1;
        state_d      = ST_INT_MUL;
      end
      ST_INT_MUL: begin
        cmd_o.int_mul = 1'b1;
        state_d       = ST_INT_ACC;
      end
      ST_INT_ACC: begin
        cmd_o.int_acc = 1'b1;
        if (step_q == fte_pkg::STEP_LAST) begin
          state_d = ST_IDLE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_INT_RD;
        end
      end
      ST_RD_A: begin
        cmd_o.rd_a = 1'b1;
        state_d    = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_b = 1'b1;
        state_d    = ST_RD_G;
      end
      ST_RD_G: begin
        cmd_o.rd_g = 1'b1;
        state_d    = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_ERR_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.push_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[design/fte_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fte_dp
// datapath: item registers, three stores, multiplier, rounding and
// saturating accumulate, output register
// ----------------------------------------------------------------------------
module fte_dp #(
  parameter int MAX_BASIS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic        [fte_pkg::BC_W-1:0]    cfg_wdata_i,
  input  wire fte_pkg::cmd_t                      cmd_i,
  output fte_pkg::sts_t                           sts_o,
  input  wire logic        [fte_pkg::KIND_W-1:0]  kind_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]   row_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]   column_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]   index_i_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]   index_j_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]   index_k_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]   index_l_i,
  input  wire logic signed [fte_pkg::VAL_W-1:0]   element_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic             [fte_pkg::IDX_W-1:0]   out_row_o,
  output logic             [fte_pkg::IDX_W-1:0]   out_column_o,
  output logic signed      [fte_pkg::ACC_W-1:0]   coulomb_exchange_o,
  output logic signed      [fte_pkg::ACC_W-1:0]   effective_one_electron_o,
  output logic                                    status_o
);

  localparam int DEPTH = MAX_BASIS * MAX_BASIS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = fte_pkg::IDX_W;
  localparam int AccW  = fte_pkg::ACC_W;

  typedef logic [IW-1:0] idx_t;

  function automatic logic [AW-1:0] at(input idx_t r, input idx_t c);
    at = AW'(32'(r) * MAX_BASIS + 32'(c));
  endfunction

  function automatic logic idx_bad(input idx_t x, input logic [fte_pkg::BC_W-1:0] bc);
    idx_bad = (32'(x) >= MAX_BASIS) || ({1'b0, x} >= bc);
  endfunction

  function automatic logic signed [AccW-1:0] sat(input logic signed [AccW:0] x);
    if (x[AccW] != x[AccW-1]) begin
      sat = x[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sat = x[AccW-1:0];
    end
  endfunction

  // configuration and item registers
  logic [fte_pkg::BC_W-1:0]          bc_q;
  logic [fte_pkg::KIND_W-1:0]        kind_q;
  idx_t                              row_q, col_q, i_q, j_q, k_q, l_q;
  logic signed [fte_pkg::VAL_W-1:0]  val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= fte_pkg::BC_RESET;
    end else if (cfg_we_i) begin
      bc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      row_q  <= row_i;
      col_q  <= column_i;
      i_q    <= index_i_i;
      j_q    <= index_j_i;
      k_q    <= index_k_i;
      l_q    <= index_l_i;
      val_q  <= element_value_i;
    end
  end

  logic bad;
  always_comb begin
    if (kind_q == fte_pkg::KIND_INTEGRAL) begin
      bad = idx_bad(i_q, bc_q) || idx_bad(j_q, bc_q) ||
            idx_bad(k_q, bc_q) || idx_bad(l_q, bc_q);
    end else begin
      bad = idx_bad(row_q, bc_q) || idx_bad(col_q, bc_q);
    end
  end

  // clearing sweep counter
  logic [AW-1:0] sweep_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.capture) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  // per-step density source, accumulator target, shift and sign
  logic [1:0] halves;
  assign halves = 2'(i_q == j_q) + 2'(k_q == l_q) + 2'((i_q == k_q) && (j_q == l_q));

  logic [AW-1:0] dens_step_addr, acc_step_addr;
  logic          step_neg;
  always_comb begin
    case (cmd_i.step)
      3'd0:    begin dens_step_addr = at(k_q, l_q); acc_step_addr = at(i_q, j_q); end
      3'd1:    begin dens_step_addr = at(i_q, j_q); acc_step_addr = at(k_q, l_q); end
      3'd2:    begin dens_step_addr = at(l_q, j_q); acc_step_addr = at(i_q, k_q); end
      3'd3:    begin dens_step_addr = at(k_q, i_q); acc_step_addr = at(j_q, l_q); end
      3'd4:    begin dens_step_addr = at(k_q, j_q); acc_step_addr = at(i_q, l_q); end
      default: begin dens_step_addr = at(l_q, i_q); acc_step_addr = at(j_q, k_q); end
    endcase
    step_neg = (cmd_i.step > 3'd1);
  end

  // stores
  logic [fte_pkg::VAL_W-1:0] dens_rdata, core_rdata;
  logic [AccW-1:0]           acc_rdata;
  logic                      acc_we, acc_re;
  logic [AW-1:0]             acc_waddr, acc_raddr;
  logic [AccW-1:0]           acc_wdata;
  logic signed [AccW-1:0]    acc_sum;

  fte_ram #(.WIDTH(fte_pkg::VAL_W), .DEPTH(DEPTH)) u_dens (
    .clk_i   (clk_i),
    .we_i    (cmd_i.dens_we),
    .waddr_i (at(row_q, col_q)),
    .wdata_i (val_q),
    .re_i    (cmd_i.int_rd),
    .raddr_i (dens_step_addr),
    .rdata_o (dens_rdata)
  );

  fte_ram #(.WIDTH(fte_pkg::VAL_W), .DEPTH(DEPTH)) u_core (
    .clk_i   (clk_i),
    .we_i    (cmd_i.core_we),
    .waddr_i (at(row_q, col_q)),
    .wdata_i (val_q),
    .re_i    (cmd_i.rd_a),
    .raddr_i (at(row_q, col_q)),
    .rdata_o (core_rdata)
  );

  assign acc_we    = cmd_i.sweep || cmd_i.int_acc;
  assign acc_waddr = cmd_i.sweep ? sweep_q : acc_step_addr;
  assign acc_wdata = cmd_i.sweep ? '0 : acc_sum;
  assign acc_re    = cmd_i.int_rd || cmd_i.rd_a || cmd_i.rd_b;
  assign acc_raddr = cmd_i.int_rd ? acc_step_addr :
                     cmd_i.rd_a   ? at(row_q, col_q) : at(col_q, row_q);

  fte_ram #(.WIDTH(AccW), .DEPTH(DEPTH)) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // multiply, round to nearest with ties up, saturating accumulate
  logic signed [fte_pkg::PROD_W-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.int_mul) begin
      prod_q <= $signed(dens_rdata) * val_q;
    end
  end

  logic [4:0]                        shamt;
  logic signed [fte_pkg::PROD_W-1:0] rnd_sum, rnd_shift;
  logic signed [AccW:0]              addend;
  always_comb begin
    shamt     = (step_neg ? fte_pkg::SHIFT_EXCH : fte_pkg::SHIFT_COULOMB) + 5'(halves);
    rnd_sum   = prod_q + (64'sd1 <<< (shamt - 5'd1));
    rnd_shift = rnd_sum >>> shamt;
    addend    = step_neg ? -rnd_shift[AccW:0] : rnd_shift[AccW:0];
    acc_sum   = sat({acc_rdata[AccW-1], acc_rdata} + addend);
  end

  // symmetrized read
  logic signed [AccW-1:0] hold_q, g_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_b) begin
      hold_q <= acc_rdata;
    end
    if (cmd_i.rd_g) begin
      g_q <= sat({hold_q[AccW-1], hold_q} + {acc_rdata[AccW-1], acc_rdata});
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push || cmd_i.push_err) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.push_err) begin
      out_row_o    <= row_q;
      out_column_o <= col_q;
      status_o     <= cmd_i.push_err;
      if (cmd_i.push) begin
        coulomb_exchange_o       <= g_q;
        effective_one_electron_o <= sat({g_q[AccW-1], g_q} +
                                        (AccW + 1)'($signed(core_rdata)));
      end else begin
        coulomb_exchange_o       <= '0;
        effective_one_electron_o <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.kind       = kind_q;
  assign sts_o.bad        = bad;
  assign sts_o.sweep_last = (sweep_q == AW'(DEPTH - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

[design/fock_two_electron_accumulate_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fock_two_electron_accumulate_unit
// two-electron coulomb-exchange matrix builder with symmetrized read-out
// ----------------------------------------------------------------------------
// The unit takes one item at a time. Every item passes an accept state
// and a decode state; a density or core load ends there. An integral
// then runs six update steps, each a density and accumulator read, a
// registered 32x32 multiply and a rounded saturating write-back through
// the single accumulator write port. A read fetches the core entry and
// both accumulator entries, sums the latter two and waits for the output
// register. A clear, and the clearing pass right after reset, sweep all
// MAX_BASIS*MAX_BASIS entries (4096 at the default) of the accumulator
// memory one entry per cycle, during which no item is taken; basis_count
// writes are taken at any time. The result sits in an output register, so
// the next item is accepted while a result still waits downstream.
// ----------------------------------------------------------------------------
module fock_two_electron_accumulate_unit #(
  parameter int MAX_BASIS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration: basis_count
  input  wire logic                              cfg_we_i,
  input  wire logic        [fte_pkg::BC_W-1:0]   cfg_wdata_i,
  // item input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic        [fte_pkg::KIND_W-1:0] kind_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]  row_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]  column_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]  index_i_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]  index_j_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]  index_k_i,
  input  wire logic        [fte_pkg::IDX_W-1:0]  index_l_i,
  input  wire logic signed [fte_pkg::VAL_W-1:0]  element_value_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic             [fte_pkg::IDX_W-1:0]  out_row_o,
  output logic             [fte_pkg::IDX_W-1:0]  out_column_o,
  output logic signed      [fte_pkg::ACC_W-1:0]  coulomb_exchange_o,
  output logic signed      [fte_pkg::ACC_W-1:0]  effective_one_electron_o,
  output logic                                   status_o
);

  fte_pkg::cmd_t cmd;
  fte_pkg::sts_t sts;

  // sequencer: accept, decode, sweep, integral steps, read-out
  fte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, arithmetic and the output register
  fte_dp #(.MAX_BASIS(MAX_BASIS)) u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .cmd_i                    (cmd),
    .sts_o                    (sts),
    .kind_i                   (kind_i),
    .row_i                    (row_i),
    .column_i                 (column_i),
    .index_i_i                (index_i_i),
    .index_j_i                (index_j_i),
    .index_k_i                (index_k_i),
    .index_l_i                (index_l_i),
    .element_value_i          (element_value_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .out_row_o                (out_row_o),
    .out_column_o             (out_column_o),
    .coulomb_exchange_o       (coulomb_exchange_o),
    .effective_one_electron_o (effective_one_electron_o),
    .status_o                 (status_o)
  );

endmodule
`default_nettype wire
